>>> rtl/rrsp_pkg.sv
// ----------------------------------------------------------------------------
// rrsp_pkg
// Shared types and fixed field widths for the round robin servo PWM block.
// ----------------------------------------------------------------------------
package rrsp_pkg;

  // Fixed request and result field widths
  localparam int ChanW  = 3;
  localparam int WidthW = 16;
  localparam int PinW   = 8;

  // Request command codes
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } command_e;

endpackage

>>> rtl/round_robin_servo_pwm.sv
// A result is registered when its request is taken.
// Throughput: one request per cycle unless the result side stalls; the
// channel tables are flop arrays read at one index and written at one index
// per cycle, with the result register taking the updated pin word.
// Reset: pointer to channel 0, all pins low, all channels disabled; counters
// and reload widths are not reset and are set by a load before use.
// ----------------------------------------------------------------------------
// round_robin_servo_pwm
// Multi-channel pulse generator. Tick requests service one channel at a time,
// round robin; load requests set a channel's high and low widths.
// ----------------------------------------------------------------------------
module round_robin_servo_pwm #(
  parameter int CHANNELS   = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rrsp_pkg::command_e           command_i,
  input  logic [rrsp_pkg::ChanW-1:0]   channel_i,
  input  logic [rrsp_pkg::WidthW-1:0]  high_width_i,
  input  logic [rrsp_pkg::WidthW-1:0]  low_width_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rrsp_pkg::ChanW-1:0]   serviced_channel_o,
  output logic [rrsp_pkg::PinW-1:0]    pin_levels_o,
  output logic                         edge_res_o
);
  import rrsp_pkg::*;

  localparam int PtrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IdxW = (PtrW > ChanW) ? PtrW : ChanW;
  localparam int ExtW = (COUNT_BITS > WidthW) ? COUNT_BITS : WidthW;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(CHANNELS - 1);
  localparam logic [ExtW-1:0] CountMax = {ExtW{1'b1}} >> (ExtW - COUNT_BITS);

  // Channel state
  logic [PtrW-1:0]       ptr_q, ptr_d;
  logic [CHANNELS-1:0]   level_q, level_d;
  logic [CHANNELS-1:0]   enabled_q, enabled_d;
  logic [COUNT_BITS-1:0] high_cnt_q [CHANNELS];
  logic [COUNT_BITS-1:0] low_cnt_q  [CHANNELS];
  logic [COUNT_BITS-1:0] high_rel_q [CHANNELS];
  logic [COUNT_BITS-1:0] low_rel_q  [CHANNELS];

  // Result register
  logic              out_valid_q, out_valid_d;
  logic [ChanW-1:0]  served_q, served_d;
  logic [PinW-1:0]   pins_q, pins_d;
  logic              edge_q, edge_d;

  logic                  accept;
  logic                  is_load;
  logic [IdxW-1:0]       ch_ext;
  logic [IdxW-1:0]       ptr_ext;
  logic [PtrW-1:0]       ld_idx;
  logic                  ch_ok;
  logic [COUNT_BITS-1:0] fit_high, fit_low;
  logic [COUNT_BITS-1:0] cur_cnt, dec_cnt;
  logic                  hit;
  logic [PtrW-1:0]       wr_idx;
  logic                  high_we, low_we, rel_we;
  logic [COUNT_BITS-1:0] high_wval, low_wval;

  // Width saturation: zero goes to one, overrange to the counter maximum
  function automatic logic [COUNT_BITS-1:0] fit_width(input logic [WidthW-1:0] w);
    logic [ExtW-1:0] w_ext;
    logic [ExtW-1:0] r;
    w_ext = ExtW'(w);
    if (w_ext == '0) begin
      r = ExtW'(1);
    end else if (w_ext > CountMax) begin
      r = CountMax;
    end else begin
      r = w_ext;
    end
    return r[COUNT_BITS-1:0];
  endfunction

  // Handshake: take a request when the result slot is free or draining
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_load    = (command_i == CMD_LOAD);

  // Index decode
  assign ch_ext  = IdxW'(channel_i);
  assign ld_idx  = ch_ext[PtrW-1:0];
  assign ch_ok   = (5'(channel_i) < 5'(CHANNELS));
  assign ptr_ext = IdxW'(ptr_q);

  assign fit_high = fit_width(high_width_i);
  assign fit_low  = fit_width(low_width_i);

  // Serviced channel count-down
  assign cur_cnt = level_q[ptr_q] ? high_cnt_q[ptr_q] : low_cnt_q[ptr_q];
  assign dec_cnt = cur_cnt - COUNT_BITS'(1);
  assign hit     = (dec_cnt == '0);

  // Next state and result
  always_comb begin
    ptr_d     = ptr_q;
    level_d   = level_q;
    enabled_d = enabled_q;
    wr_idx    = ptr_q;
    high_we   = 1'b0;
    low_we    = 1'b0;
    rel_we    = 1'b0;
    high_wval = dec_cnt;
    low_wval  = dec_cnt;
    edge_d    = 1'b0;
    served_d  = ptr_ext[ChanW-1:0];
    if (is_load) begin
      served_d  = channel_i;
      wr_idx    = ld_idx;
      high_wval = fit_high;
      low_wval  = fit_low;
      if (accept && ch_ok) begin
        high_we         = 1'b1;
        low_we          = 1'b1;
        rel_we          = 1'b1;
        edge_d          = level_q[ld_idx];
        level_d[ld_idx] = 1'b0;
        enabled_d[ld_idx] = 1'b1;
      end
    end else if (accept) begin
      ptr_d = (ptr_q == LastPtr) ? '0 : ptr_q + PtrW'(1);
      if (enabled_q[ptr_q]) begin
        if (level_q[ptr_q]) begin
          high_we = 1'b1;
          if (hit) begin
            high_wval      = high_rel_q[ptr_q];
            level_d[ptr_q] = 1'b0;
            edge_d         = 1'b1;
          end
        end else begin
          low_we = 1'b1;
          if (hit) begin
            low_wval       = low_rel_q[ptr_q];
            level_d[ptr_q] = 1'b1;
            edge_d         = 1'b1;
          end
        end
      end
    end
  end

  // Visible pin word: first eight channels only
  always_comb begin
    pins_d = '0;
    for (int i = 0; i < PinW; i++) begin
      if (i < CHANNELS) begin
        pins_d[i] = level_d[i];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      level_q     <= '0;
      enabled_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q       <= ptr_d;
      level_q     <= level_d;
      enabled_q   <= enabled_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Channel tables, one write index per cycle
  always_ff @(posedge clk_i) begin
    if (high_we) begin
      high_cnt_q[wr_idx] <= high_wval;
    end
    if (low_we) begin
      low_cnt_q[wr_idx] <= low_wval;
    end
    if (rel_we) begin
      high_rel_q[wr_idx] <= fit_high;
      low_rel_q[wr_idx]  <= fit_low;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      served_q <= served_d;
      pins_q   <= pins_d;
      edge_q   <= edge_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign serviced_channel_o = served_q;
  assign pin_levels_o       = pins_q;
  assign edge_res_o         = edge_q;

endmodule

>>> verif/rrsp_checker.sv
// ----------------------------------------------------------------------------
// rrsp_checker
// Watches both request and result channels of the round robin servo PWM,
// keeps a shadow of every channel's level, counters and widths, and compares
// each accepted result field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module rrsp_checker
  import rrsp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  command_e            command_i,
  input  logic [ChanW-1:0]    channel_i,
  input  logic [WidthW-1:0]   high_width_i,
  input  logic [WidthW-1:0]   low_width_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [ChanW-1:0]    serviced_channel_i,
  input  logic [PinW-1:0]     pin_levels_i,
  input  logic                edge_res_i,
  output int                  pending_o,
  output int                  failures_o,
  output int                  toggles_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumChan = 8;

  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic [PinW-1:0]  pins;
    logic             toggled;
  } pulse_result_t;

  // Shadow of the block's channel tables
  logic [ChanW-1:0]  service_ptr;
  logic [PinW-1:0]   pin_level;
  logic [PinW-1:0]   chan_enabled;
  logic [WidthW-1:0] high_left   [NumChan];
  logic [WidthW-1:0] low_left    [NumChan];
  logic [WidthW-1:0] high_reload [NumChan];
  logic [WidthW-1:0] low_reload  [NumChan];

  pulse_result_t expected_pulses_q[$];
  int            mismatches;
  int            toggles_seen;

  assign failures_o = mismatches;
  assign toggles_o  = toggles_seen;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // A zero width behaves as one service
  function automatic logic [WidthW-1:0] sat_width(input logic [WidthW-1:0] w);
    return (w == '0) ? WidthW'(1) : w;
  endfunction

  // Advance the shadow by one request and return what the block should report
  function automatic pulse_result_t predict_pulse(input command_e cmd,
                                                  input logic [ChanW-1:0] ch,
                                                  input logic [WidthW-1:0] hw,
                                                  input logic [WidthW-1:0] lw);
    pulse_result_t    r;
    logic [ChanW-1:0] p;
    r.toggled = 1'b0;
    if (cmd == CMD_LOAD) begin
      r.chan          = ch;
      high_reload[ch] = sat_width(hw);
      low_reload[ch]  = sat_width(lw);
      high_left[ch]   = high_reload[ch];
      low_left[ch]    = low_reload[ch];
      r.toggled       = pin_level[ch];
      pin_level[ch]   = 1'b0;
      chan_enabled[ch] = 1'b1;
    end else begin
      p      = service_ptr;
      r.chan = p;
      if (chan_enabled[p]) begin
        if (pin_level[p]) begin
          high_left[p] = high_left[p] - 1'b1;
          if (high_left[p] == '0) begin
            pin_level[p] = 1'b0;
            high_left[p] = high_reload[p];
            r.toggled    = 1'b1;
          end
        end else begin
          low_left[p] = low_left[p] - 1'b1;
          if (low_left[p] == '0) begin
            pin_level[p] = 1'b1;
            low_left[p]  = low_reload[p];
            r.toggled    = 1'b1;
          end
        end
      end
      // eight channels, so the 3-bit pointer wraps by itself
      service_ptr = p + 1'b1;
    end
    r.pins = pin_level;
    return r;
  endfunction

  // Results are checked before new requests are predicted at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    pulse_result_t want;
    if (!rst_ni) begin
      service_ptr  = '0;
      pin_level    = '0;
      chan_enabled = '0;
      expected_pulses_q.delete();
      pending_o    = 0;
      mismatches   = 0;
      toggles_seen = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_pulses_q.size() == 0) begin
          report_mismatch("unexpected result, channel", serviced_channel_i, -1);
        end else begin
          want = expected_pulses_q.pop_front();
          if (serviced_channel_i !== want.chan)
            report_mismatch("serviced_channel", serviced_channel_i, want.chan);
          if (pin_levels_i !== want.pins)
            report_mismatch("pin_levels", pin_levels_i, want.pins);
          if (edge_res_i !== want.toggled)
            report_mismatch("edge_res", edge_res_i, want.toggled);
          if (want.toggled)
            toggles_seen++;
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_pulses_q.push_back(predict_pulse(command_i, channel_i,
                                                  high_width_i, low_width_i));
      pending_o = expected_pulses_q.size();
    end
  end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the round robin servo PWM: directed loads and ticks over the
// width extremes, then random request streams with random sender gaps and
// receiver stalls. Checking is done by rrsp_checker beside the block.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrsp_pkg::*;

  localparam int RandomReqs = 450;
  localparam int CycleLimit = 400_000;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  command_e          command_i;
  logic [ChanW-1:0]  channel_i;
  logic [WidthW-1:0] high_width_i;
  logic [WidthW-1:0] low_width_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [ChanW-1:0]  serviced_channel_o;
  logic [PinW-1:0]   pin_levels_o;
  logic              edge_res_o;

  int pending_pulses;
  int mismatch_count;
  int toggle_count;
  int tick_reqs;
  int load_reqs;
  int cycle_count;
  bit no_idle;

  round_robin_servo_pwm dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .channel_i          (channel_i),
    .high_width_i       (high_width_i),
    .low_width_i        (low_width_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .serviced_channel_o (serviced_channel_o),
    .pin_levels_o       (pin_levels_o),
    .edge_res_o         (edge_res_o)
  );

  rrsp_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .command_i          (command_i),
    .channel_i          (channel_i),
    .high_width_i       (high_width_i),
    .low_width_i        (low_width_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .serviced_channel_i (serviced_channel_o),
    .pin_levels_i       (pin_levels_o),
    .edge_res_i         (edge_res_o),
    .pending_o          (pending_pulses),
    .failures_o         (mismatch_count),
    .toggles_o          (toggle_count)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_pulses);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: a fresh stall length is drawn for every accepted result
  initial begin
    int hold;
    hold        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i)
        hold = no_idle ? 0 : $urandom_range(0, 19);
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Drive one request after a random gap and hold it until taken
  task automatic send_request(input command_e cmd, input logic [ChanW-1:0] ch,
                              input logic [WidthW-1:0] hw,
                              input logic [WidthW-1:0] lw);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    channel_i    <= ch;
    high_width_i <= hw;
    low_width_i  <= lw;
    do @(posedge clk_i); while (in_stall_o);
    if (cmd == CMD_LOAD) load_reqs++;
    else tick_reqs++;
  endtask

  task automatic tick_n(input int n);
    repeat (n) send_request(CMD_TICK, ChanW'($urandom), WidthW'($urandom),
                            WidthW'($urandom));
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_pulses != 0);
  endtask

  // Mostly short widths so channels toggle often, some full range, some extremes
  function automatic logic [WidthW-1:0] rand_width();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) return WidthW'($urandom_range(0, 6));
    if (sel < 95) return WidthW'($urandom);
    return (sel[0]) ? '1 : '0;
  endfunction

  // Stimulus and verdict
  initial begin
    int phase_left;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    command_i    = CMD_TICK;
    channel_i    = '0;
    high_width_i = '0;
    low_width_i  = '0;
    no_idle      = 1'b0;
    tick_reqs    = 0;
    load_reqs    = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: ticks on unloaded channels, width extremes, reload of a high pin
    tick_n(2);
    send_request(CMD_LOAD, 3'd0, 16'h0000, 16'h0000);
    send_request(CMD_LOAD, 3'd7, 16'hFFFF, 16'hFFFF);
    send_request(CMD_LOAD, 3'd1, 16'h0001, 16'h0002);
    tick_n(14);
    send_request(CMD_LOAD, 3'd0, 16'h0003, 16'h0001);
    send_request(CMD_LOAD, 3'd2, 16'hAAAA, 16'h5555);
    tick_n(3);
    drain_results();

    // Random: each phase is drawn as back-to-back traffic or as traffic with idling
    phase_left = 0;
    for (int i = 0; i < RandomReqs; i++) begin
      if (phase_left == 0) begin
        no_idle    = ($urandom_range(0, 2) == 0);
        phase_left = $urandom_range(10, 50);
      end
      phase_left--;
      if (i == RandomReqs / 2) drain_results();
      if ($urandom_range(0, 4) == 0)
        send_request(CMD_LOAD, ChanW'($urandom), rand_width(), rand_width());
      else
        send_request(CMD_TICK, ChanW'($urandom), WidthW'($urandom),
                     WidthW'($urandom));
    end
    no_idle = 1'b0;

    // Wind down: everything back, then a quiet wait for strays
    drain_results();
    repeat (10) @(posedge clk_i);

    $display("Covered %0d tick and %0d load requests, %0d pin toggles checked",
             tick_reqs, load_reqs, toggle_count);
    if (mismatch_count == 0 && pending_pulses == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rrsp_pkg.sv
rtl/round_robin_servo_pwm.sv
verif/rrsp_checker.sv
verif/tb.sv
